@@ hw/rtl/oss_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package oss_pkg;

    localparam int OSS_CAPACITY = 16;
    localparam int KIND_W       = 2;
    localparam int VALUE_W      = 32;
    localparam int COUNT_OUT_W  = 5;

    typedef logic [KIND_W-1:0]         kind_t;
    typedef logic signed [VALUE_W-1:0] value_t;

    localparam kind_t KIND_ADD    = 2'd0;
    localparam kind_t KIND_REMOVE = 2'd1;
    localparam kind_t KIND_QUERY  = 2'd2;
    localparam kind_t KIND_CLEAR  = 2'd3;

endpackage

`default_nettype wire

@@ hw/rtl/oss_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

module oss_mem
    import oss_pkg::*;
#(
    parameter int DEPTH = OSS_CAPACITY,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire value_t        wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output value_t             rd_data
);

    value_t mem_array [0:DEPTH-1];
    value_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_array[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hw/rtl/ordered_set_store_core.sv @@
// channel   signals                              handshake
// command   kind, value                          accepted when start high and busy low
// result    success, member_count, full_reject   one beat, valid while done is high
//
// clear: busy stays low, result beat in the cycle after the accepting edge
// lookup: a registered read, then a compare, for each entry compared; an absent value ends in a last read step
// remove: each entry behind the removed one moves down by a read and a write; a last read step ends it
// result beat in the same cycle that busy falls; reset clears the count and the control state
// entry memory is not cleared; the receiver cannot stall: each result beat shows for one cycle
`timescale 1ns / 1ps
`default_nettype none

module ordered_set_store_core
    import oss_pkg::*;
#(
    parameter int CAPACITY = OSS_CAPACITY
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire kind_t                  kind,
    input  wire value_t                 value,
    output logic                        done,
    output logic                        success,
    output logic [COUNT_OUT_W-1:0]      member_count,
    output logic                        full_reject
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_READ     = 3'd1;
    localparam logic [2:0] S_CMP      = 3'd2;
    localparam logic [2:0] S_SHIFT_RD = 3'd3;
    localparam logic [2:0] S_SHIFT_WR = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          idx_inc;
    kind_t                  kind_reg, kind_next;
    value_t                 value_reg, value_next;
    logic                   done_reg, done_next;
    logic                   success_reg, success_next;
    logic                   reject_reg, reject_next;
    logic [COUNT_OUT_W-1:0] member_count_reg, member_count_next;
    logic [CW+COUNT_OUT_W-1:0] count_wide;

    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    value_t        mem_wr_data;
    logic [AW-1:0] mem_rd_addr;
    value_t        mem_rd_data;

    oss_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign idx_inc = idx_reg + 1'b1;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        kind_next    = kind_reg;
        value_next   = value_reg;
        done_next    = 1'b0;
        success_next = success_reg;
        reject_next  = reject_reg;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = idx_reg[AW-1:0];
        mem_wr_data  = value_reg;
        mem_rd_addr  = idx_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next  = kind;
                    value_next = value;
                    idx_next   = '0;
                    if (kind == KIND_CLEAR)
                    begin
                        count_next   = '0;
                        done_next    = 1'b1;
                        success_next = 1'b0;
                        reject_next  = 1'b0;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                if (idx_reg == count_reg)
                begin
                    // value absent
                    state_next   = S_IDLE;
                    done_next    = 1'b1;
                    success_next = 1'b0;
                    reject_next  = 1'b0;
                    if (kind_reg == KIND_ADD)
                    begin
                        if (count_reg == CAP_C)
                        begin
                            reject_next = 1'b1;
                        end
                        else
                        begin
                            mem_wr_en    = 1'b1;
                            mem_wr_addr  = count_reg[AW-1:0];
                            count_next   = count_reg + 1'b1;
                            success_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (mem_rd_data == value_reg)
                begin
                    if (kind_reg == KIND_REMOVE)
                    begin
                        state_next = S_SHIFT_RD;
                    end
                    else
                    begin
                        state_next   = S_IDLE;
                        done_next    = 1'b1;
                        success_next = (kind_reg == KIND_QUERY);
                        reject_next  = 1'b0;
                    end
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_READ;
                end
            end
            S_SHIFT_RD:
            begin
                mem_rd_addr = idx_inc[AW-1:0];
                if (idx_inc == count_reg)
                begin
                    count_next   = count_reg - 1'b1;
                    state_next   = S_IDLE;
                    done_next    = 1'b1;
                    success_next = 1'b1;
                    reject_next  = 1'b0;
                end
                else
                begin
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = idx_reg[AW-1:0];
                mem_wr_data = mem_rd_data;
                idx_next    = idx_inc;
                state_next  = S_SHIFT_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign count_wide        = {{COUNT_OUT_W{1'b0}}, count_next};
    assign member_count_next = count_wide[COUNT_OUT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg          <= idx_next;
        kind_reg         <= kind_next;
        value_reg        <= value_next;
        success_reg      <= success_next;
        reject_reg       <= reject_next;
        member_count_reg <= member_count_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign success      = success_reg;
    assign full_reject  = reject_reg;
    assign member_count = member_count_reg;

endmodule

`default_nettype wire

@@ hw/rtl/oss_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module oss_checker
    import oss_pkg::*;
#(
    parameter int CAPACITY = OSS_CAPACITY
) (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   start,
    input wire logic                   busy,
    input wire logic                   done,
    input wire logic                   success,
    input wire logic [COUNT_OUT_W-1:0] member_count,
    input wire logic                   full_reject
);

    // every accepted command leads to work or to a result beat
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted command neither started nor finished");

    a_done_ready: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while still busy");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(success && full_reject))
        else $error("success and full reject together");

    a_busy_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a command");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((CAPACITY > 31) || (int'(member_count) <= CAPACITY)))
        else $error("member count above capacity");

endmodule

bind ordered_set_store_core oss_checker #(
    .CAPACITY (CAPACITY)
) u_oss_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .success      (success),
    .member_count (member_count),
    .full_reject  (full_reject)
);

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import oss_pkg::*;

    localparam int CAPACITY      = OSS_CAPACITY;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int POOL_SIZE     = 24;
    localparam int MAX_GAP       = 18;
    localparam int TAIL_CYCLES   = 4 * CAPACITY + 10;
    localparam int IDLE_LIMIT    = 20 * (4 * CAPACITY + 2 + MAX_GAP);

    typedef struct packed {
        logic                   success;
        logic [COUNT_OUT_W-1:0] member_count;
        logic                   full_reject;
    } set_result_t;

    typedef struct {
        kind_t       k;
        value_t      v;
        int          rep;
        logic        typed;
        set_result_t res;
    } cmd_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    kind_t                  kind;
    value_t                 value;
    logic                   done;
    logic                   success;
    logic [COUNT_OUT_W-1:0] member_count;
    logic                   full_reject;

    logic        typed_now;
    set_result_t typed_result;

    value_t      shadow_entries [CAPACITY];
    int          shadow_count;
    set_result_t results_due [$];
    cmd_row_t    directed_rows [$];
    value_t      value_pool [POOL_SIZE];

    int fail_count;
    int n_add;
    int n_remove;
    int n_query;
    int n_clear;
    int n_reject;
    int n_checked;
    int idle_cycles;

    ordered_set_store_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .value        (value),
        .done         (done),
        .success      (success),
        .member_count (member_count),
        .full_reject  (full_reject)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic apply_set_op(input kind_t k, input value_t v, output set_result_t res);
        int pos;
        pos = shadow_count;
        for (int i = 0; i < shadow_count; i++)
        begin
            if (shadow_entries[i] == v && pos == shadow_count)
                pos = i;
        end
        res = '0;
        case (k)
            KIND_ADD:
            begin
                n_add++;
                if (pos == shadow_count)
                begin
                    if (shadow_count < CAPACITY)
                    begin
                        shadow_entries[shadow_count] = v;
                        shadow_count++;
                        res.success = 1'b1;
                    end
                    else
                    begin
                        res.full_reject = 1'b1;
                        n_reject++;
                    end
                end
            end
            KIND_REMOVE:
            begin
                n_remove++;
                if (pos < shadow_count)
                begin
                    for (int i = pos; i + 1 < shadow_count; i++)
                        shadow_entries[i] = shadow_entries[i + 1];
                    shadow_count--;
                    res.success = 1'b1;
                end
            end
            KIND_QUERY:
            begin
                n_query++;
                res.success = (pos < shadow_count);
            end
            default:
            begin
                n_clear++;
                shadow_count = 0;
            end
        endcase
        res.member_count = shadow_count[COUNT_OUT_W-1:0];
    endtask

    always @(posedge clk)
    begin
        set_result_t exp_res;
        set_result_t got_res;
        logic        active;
        active = 1'b0;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                active = 1'b1;
                got_res = '{success, member_count, full_reject};
                if (results_due.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end
                else
                begin
                    exp_res = results_due.pop_front();
                    n_checked++;
                    if (got_res.success !== exp_res.success)
                    begin
                        $error("success: expected %0d, actual %0d",
                               exp_res.success, got_res.success);
                        fail_count++;
                    end
                    if (got_res.member_count !== exp_res.member_count)
                    begin
                        $error("member_count: expected %0d, actual %0d",
                               exp_res.member_count, got_res.member_count);
                        fail_count++;
                    end
                    if (got_res.full_reject !== exp_res.full_reject)
                    begin
                        $error("full_reject: expected %0d, actual %0d",
                               exp_res.full_reject, got_res.full_reject);
                        fail_count++;
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                active = 1'b1;
                apply_set_op(kind, value, exp_res);
                if (typed_now)
                    exp_res = typed_result;
                results_due.push_back(exp_res);
            end
            idle_cycles = active ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles", idle_cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic send_cmd(input kind_t k, input value_t v, input logic typed,
                            input set_result_t res, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        kind         <= k;
        value        <= v;
        typed_now    <= typed;
        typed_result <= res;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic add_row(input kind_t k, input value_t v, input int rep, input logic typed,
                           input logic s, input int c, input logic fr);
        cmd_row_t r;
        r.k     = k;
        r.v     = v;
        r.rep   = rep;
        r.typed = typed;
        r.res   = '{s, c[COUNT_OUT_W-1:0], fr};
        directed_rows.push_back(r);
    endtask

    function automatic int draw_gap(input logic burst);
        return burst ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    initial
    begin
        logic   burst;
        int     pick;
        kind_t  k;
        value_t v;

        rst_n        = 1'b0;
        start        = 1'b0;
        kind         = KIND_QUERY;
        value        = '0;
        typed_now    = 1'b0;
        typed_result = '0;
        fail_count   = 0;
        n_add        = 0;
        n_remove     = 0;
        n_query      = 0;
        n_clear      = 0;
        n_reject     = 0;
        n_checked    = 0;
        idle_cycles  = 0;
        shadow_count = 0;
        for (int i = 0; i < CAPACITY; i++)
            shadow_entries[i] = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        add_row(KIND_QUERY,  value_t'(0),            1, 1'b1, 1'b0,  0, 1'b0);
        add_row(KIND_REMOVE, value_t'(5),            1, 1'b1, 1'b0,  0, 1'b0);
        add_row(KIND_ADD,    value_t'(32'h7fffffff), 1, 1'b1, 1'b1,  1, 1'b0);
        add_row(KIND_ADD,    value_t'(32'h80000000), 1, 1'b1, 1'b1,  2, 1'b0);
        add_row(KIND_ADD,    value_t'(32'h7fffffff), 1, 1'b1, 1'b0,  2, 1'b0);
        add_row(KIND_QUERY,  value_t'(32'h80000000), 1, 1'b1, 1'b1,  2, 1'b0);
        add_row(KIND_ADD,    value_t'(-1),           1, 1'b1, 1'b1,  3, 1'b0);
        // drop the head, then the tail
        add_row(KIND_REMOVE, value_t'(32'h7fffffff), 1, 1'b1, 1'b1,  2, 1'b0);
        add_row(KIND_REMOVE, value_t'(-1),           1, 1'b1, 1'b1,  1, 1'b0);
        // fill up to capacity
        add_row(KIND_ADD,    value_t'(0),            CAPACITY - 1, 1'b0, 1'b0, 0, 1'b0);
        add_row(KIND_ADD,    value_t'(32'h12345678), 1, 1'b1, 1'b0, 16, 1'b1);
        add_row(KIND_ADD,    value_t'(7),            1, 1'b1, 1'b0, 16, 1'b0);
        add_row(KIND_QUERY,  value_t'(14),           1, 1'b1, 1'b1, 16, 1'b0);
        add_row(KIND_REMOVE, value_t'(32'h80000000), 1, 1'b1, 1'b1, 15, 1'b0);
        add_row(KIND_ADD,    value_t'(32'h12345678), 1, 1'b1, 1'b1, 16, 1'b0);
        add_row(KIND_REMOVE, value_t'(32'h12345678), 1, 1'b1, 1'b1, 15, 1'b0);
        add_row(KIND_CLEAR,  value_t'(-1),           1, 1'b1, 1'b0,  0, 1'b0);
        // stale entries must not be found
        add_row(KIND_QUERY,  value_t'(3),            1, 1'b1, 1'b0,  0, 1'b0);

        foreach (directed_rows[i])
        begin
            for (int r = 0; r < directed_rows[i].rep; r++)
                send_cmd(directed_rows[i].k, value_t'(directed_rows[i].v + r),
                         directed_rows[i].typed, directed_rows[i].res, draw_gap(i % 4 == 0));
        end

        burst = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 300 == 0)
            begin
                value_pool[0] = value_t'(32'h7fffffff);
                value_pool[1] = value_t'(32'h80000000);
                value_pool[2] = value_t'(0);
                value_pool[3] = value_t'(-1);
                for (int i = 4; i < POOL_SIZE; i++)
                    value_pool[i] = value_t'($urandom);
            end
            if (n % 120 == 0)
                burst = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 48)
                k = KIND_ADD;
            else if (pick < 73)
                k = KIND_REMOVE;
            else if (pick < 98)
                k = KIND_QUERY;
            else
                k = KIND_CLEAR;
            if ($urandom_range(0, 99) < 85)
                v = value_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                v = value_t'($urandom);
            send_cmd(k, v, 1'b0, '0, draw_gap(burst));
        end
        start <= 1'b0;

        while (results_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (results_due.size() != 0)
        begin
            $error("%0d expected results never arrived", results_due.size());
            fail_count++;
        end

        $display("covered %0d adds, %0d removes, %0d queries, %0d clears",
                 n_add, n_remove, n_query, n_clear);
        $display("%0d full rejects predicted, %0d result beats compared",
                 n_reject, n_checked);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
